@@ rtl/timed_automaton_concrete_monitor_top_assert.svh @@
// ------------------------------------------------------------------------------------------
// Assertion macros for the concrete timed-automaton monitor
// Two wrappers around a clocked, reset-qualified concurrent assertion.
// ------------------------------------------------------------------------------------------
`ifndef TIMED_AUTOMATON_CONCRETE_MONITOR_TOP_ASSERT_SVH
`define TIMED_AUTOMATON_CONCRETE_MONITOR_TOP_ASSERT_SVH

// same-cycle implication
`define TACM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TACM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/tacm_pkg.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------------------------
// tacm_pkg
// Shared types, field layout and codes of the concrete timed-automaton monitor.
// ------------------------------------------------------------------------------------------
package tacm_pkg;

	localparam int CLOCK_SLOTS_DEF    = 16;
	localparam int LOCATION_COUNT_DEF = 256;
	localparam int TIME_BITS_DEF      = 32;

	localparam int OP_W   = 2;
	localparam int TS_W   = 32;
	localparam int SLOT_W = 4;
	localparam int BND_W  = 33;
	localparam int LOC_W  = 8;
	localparam int MASK_W = 16;
	localparam int ERR_W  = 2;
	localparam int IN_W   = 144;
	localparam int OUT_W  = 48;

	typedef enum logic [OP_W-1:0] {
		OP_ADVANCE    = 2'd0,
		OP_CHECK      = 2'd1,
		OP_TRANSITION = 2'd2,
		OP_NOP        = 2'd3
	} op_t;

	localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
	localparam logic [ERR_W-1:0] ERR_BACKWARD = 2'd1;
	localparam logic [ERR_W-1:0] ERR_INTERVAL = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ADV,
		ST_CHK_B,
		ST_CHK_EVAL,
		ST_RESP
	} state_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_CMP
	} alu_mode_t;

	typedef struct packed {
		alu_mode_t mode;
		logic      strict;
	} alu_ctl_t;

	// input beat, lowest field at the bottom
	typedef struct packed {
		logic [4:0]        pad;
		logic [MASK_W-1:0] reset_mask;
		logic [LOC_W-1:0]  to_location;
		logic [LOC_W-1:0]  from_location;
		logic              unbounded;
		logic              strict;
		logic [BND_W-1:0]  bound;
		logic [SLOT_W-1:0] clock_b;
		logic [SLOT_W-1:0] clock_a;
		logic [TS_W-1:0]   time_high;
		logic [TS_W-1:0]   time_low;
	} in_beat_t;

	typedef struct packed {
		logic [3:0]       pad;
		logic [TS_W-1:0]  global_time;
		logic [LOC_W-1:0] location_now;
		logic [ERR_W-1:0] error_code;
		logic             run_empty;
		logic             ok;
	} out_beat_t;

endpackage

@@ rtl/tacm_ram.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------------------------
// tacm_ram
// Generic single-write, single-read RAM with registered read data.
// ------------------------------------------------------------------------------------------
module tacm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/tacm_alu.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------------------------
// tacm_alu
// Shared add / subtract / difference-constraint compare unit.
// ------------------------------------------------------------------------------------------
module tacm_alu #(
	parameter int TIME_BITS = tacm_pkg::TIME_BITS_DEF
) (
	input  tacm_pkg::alu_ctl_t                ctl,
	input  logic [TIME_BITS-1:0]              x,
	input  logic [TIME_BITS-1:0]              y,
	input  logic signed [tacm_pkg::BND_W-1:0] bound,
	output logic [TIME_BITS-1:0]              result,
	output logic                              borrow,
	output logic                              holds
);
	import tacm_pkg::*;

	// wide enough for x - y and the sign-extended bound without overflow
	localparam int CW = ((TIME_BITS + 1 > BND_W) ? TIME_BITS + 1 : BND_W) + 1;

	logic [TIME_BITS:0]     sub_w;
	logic signed [CW-1:0]   diff;
	logic signed [CW-1:0]   bnd;

	always_comb begin
		sub_w  = {1'b0, x} - {1'b0, y};
		diff   = $signed(CW'(x)) - $signed(CW'(y));
		bnd    = CW'(bound);
		result = '0;
		borrow = 1'b0;
		holds  = 1'b0;
		unique case (ctl.mode)
			ALU_ADD: begin
				result = x + y;
			end
			ALU_SUB: begin
				result = sub_w[TIME_BITS-1:0];
				borrow = sub_w[TIME_BITS];
			end
			ALU_CMP: begin
				holds = ctl.strict ? (diff < bnd) : (diff <= bnd);
			end
			default: begin
				result = '0;
			end
		endcase
	end

endmodule

@@ rtl/timed_automaton_concrete_monitor_top.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------------------------
// timed_automaton_concrete_monitor_top
// Concrete timed-automaton run monitor: advance / check / transition over a clock store.
// ------------------------------------------------------------------------------------------
// Usage
//  - s_axis: one operation per beat; tuser carries the opcode, tdata the operands.
//  - m_axis: exactly one result beat per operation, in order.
//  - cfg: write start_location while idle; this restarts the run (clocks zero, not empty).
//  - Clock values live in a CLOCK_SLOTS-deep RAM; global time also sits in a register.
//    Per-slot valid flops make every slot read as zero after reset or restart.
//  - Advance walks slots 1..CLOCK_SLOTS-2 through one shared adder, one slot a cycle,
//    read and write overlapped.
//  - Check reads two slots through the registered RAM port and compares in the same unit
//    unless the run is empty or the check is unbounded. Transition and no-op skip to the result.
//  - s_axis_tready is high only while the sequencer is idle; one operation at a time.
//  - The result sits in an output register; a new beat is taken while it waits. If the
//    next result is ready before the receiver takes the old one, the sequencer holds.
//  - Reset (arst_n low): location 0, clocks zero, run not empty, no result pending.
// ------------------------------------------------------------------------------------------
module timed_automaton_concrete_monitor_top #(
	parameter int CLOCK_SLOTS    = tacm_pkg::CLOCK_SLOTS_DEF,
	parameter int LOCATION_COUNT = tacm_pkg::LOCATION_COUNT_DEF,
	parameter int TIME_BITS      = tacm_pkg::TIME_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// tdata: time_low, time_high, clock_a, clock_b, bound, strict, unbounded,
	//        from_location, to_location, reset_mask, zero pad
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [tacm_pkg::IN_W-1:0]    s_axis_tdata,
	// tuser: opcode
	input  logic [tacm_pkg::OP_W-1:0]    s_axis_tuser,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// tdata: ok, run_empty, error_code, location_now, global_time, zero pad
	output logic [tacm_pkg::OUT_W-1:0]   m_axis_tdata,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tacm_pkg::LOC_W-1:0]   cfg_data
);
	import tacm_pkg::*;

	localparam int IDX_W = $clog2(CLOCK_SLOTS);
	localparam logic [IDX_W-1:0] GSLOT_IDX = IDX_W'(CLOCK_SLOTS - 1);
	localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);

	in_beat_t beat;

	// sequencer
	state_t state_q, state_d;
	logic [IDX_W-1:0] idx_q;

	// captured operation
	op_t                op_q;
	logic [TIME_BITS-1:0] lo_q, hi_q;
	logic [SLOT_W-1:0]  ca_q, cb_q;
	logic signed [BND_W-1:0] bound_q;
	logic               strict_q, unb_q;
	logic [LOC_W-1:0]   from_q, to_q;
	logic [MASK_W-1:0]  mask_q;

	// run state
	logic [CLOCK_SLOTS-1:0] valid_q;
	logic [TIME_BITS-1:0]   global_q;
	logic [LOC_W-1:0]       loc_q;
	logic                   rej_q;

	// working registers
	logic [TIME_BITS-1:0] d_q, av_q;
	logic                 ok_q;
	logic [ERR_W-1:0]     err_q;

	// RAM read pipeline
	logic                 rd_en, rd_vld_d, rd_glob_d;
	logic [IDX_W-1:0]     rd_addr;
	logic [TIME_BITS-1:0] rd_data, rd_val;
	logic                 rd_vld_s1, rd_glob_s1, pend_s1;
	logic [IDX_W-1:0]     widx_s1;

	// shared unit
	alu_ctl_t             alu_ctl;
	logic [TIME_BITS-1:0] alu_x, alu_y, alu_result;
	logic                 alu_borrow, alu_holds;

	// output register
	logic             m_valid_q;
	out_beat_t        m_data_q;
	out_beat_t        m_data_d;
	logic             load_out;

	logic             s_acc;
	logic             a_in, a_glob, b_in, b_glob;
	logic [IDX_W-1:0] a_addr, b_addr;
	logic             trn_bad;
	logic [63:0]      mask64;

	assign beat          = in_beat_t'(s_axis_tdata);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// slots at or above CLOCK_SLOTS read zero; the global slot comes from its register
	assign a_in   = 32'(ca_q) < CLOCK_SLOTS;
	assign b_in   = 32'(cb_q) < CLOCK_SLOTS;
	assign a_glob = 32'(ca_q) == CLOCK_SLOTS - 1;
	assign b_glob = 32'(cb_q) == CLOCK_SLOTS - 1;
	assign a_addr = IDX_W'(ca_q);
	assign b_addr = IDX_W'(cb_q);

	assign trn_bad = (from_q != loc_q) || (32'(from_q) >= LOCATION_COUNT) ||
	                 (32'(to_q) >= LOCATION_COUNT);
	assign mask64  = 64'(mask_q);

	assign rd_val = rd_glob_s1 ? global_q : (rd_vld_s1 ? rd_data : '0);

	assign load_out = (state_q == ST_RESP) && (!m_valid_q || m_axis_tready);

	tacm_ram #(
		.WIDTH (TIME_BITS),
		.DEPTH (CLOCK_SLOTS)
	) u_clk_ram (
		.clk     (clk),
		.wr_en   ((state_q == ST_ADV) && pend_s1),
		.wr_addr (widx_s1),
		.wr_data (alu_result),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	tacm_alu #(
		.TIME_BITS (TIME_BITS)
	) u_alu (
		.ctl    (alu_ctl),
		.x      (alu_x),
		.y      (alu_y),
		.bound  (bound_q),
		.result (alu_result),
		.borrow (alu_borrow),
		.holds  (alu_holds)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, RAM read issue and shared-unit operand selection
	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		rd_addr   = idx_q;
		rd_vld_d  = 1'b0;
		rd_glob_d = 1'b0;
		alu_ctl   = '{mode: ALU_ADD, strict: strict_q};
		alu_x     = rd_val;
		alu_y     = d_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				// timestamp - global borrow flags time going backward
				alu_ctl.mode = ALU_SUB;
				alu_x        = lo_q;
				alu_y        = global_q;
				state_d      = ST_RESP;
				unique case (op_q)
					OP_ADVANCE: begin
						if (lo_q == hi_q && !alu_borrow) begin
							state_d = ST_ADV;
						end
					end
					OP_CHECK: begin
						if (!rej_q && !unb_q) begin
							rd_en     = a_in;
							rd_addr   = a_addr;
							rd_glob_d = a_glob;
							rd_vld_d  = a_in && !a_glob && valid_q[a_addr];
							state_d   = ST_CHK_B;
						end
					end
					OP_TRANSITION: begin
						state_d = ST_RESP;
					end
					OP_NOP: begin
						state_d = ST_RESP;
					end
					default: begin
						state_d = ST_RESP;
					end
				endcase
			end
			ST_ADV: begin
				if (idx_q != GSLOT_IDX) begin
					rd_en    = 1'b1;
					rd_addr  = idx_q;
					rd_vld_d = valid_q[idx_q];
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_CHK_B: begin
				rd_en     = b_in;
				rd_addr   = b_addr;
				rd_glob_d = b_glob;
				rd_vld_d  = b_in && !b_glob && valid_q[b_addr];
				state_d   = ST_CHK_EVAL;
			end
			ST_CHK_EVAL: begin
				alu_ctl.mode = ALU_CMP;
				alu_x        = av_q;
				alu_y        = rd_val;
				state_d      = ST_RESP;
			end
			ST_RESP: begin
				if (!m_valid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// run state and sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			global_q  <= '0;
			loc_q     <= '0;
			rej_q     <= 1'b0;
			pend_s1   <= 1'b0;
			idx_q     <= FIRST_IDX;
			m_valid_q <= 1'b0;
		end else begin
			pend_s1 <= rd_en && (state_q == ST_ADV);
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (state_q == ST_DECODE) begin
				idx_q <= FIRST_IDX;
			end else if (state_q == ST_ADV && rd_en) begin
				idx_q <= idx_q + FIRST_IDX;
			end
			if (cfg_valid) begin
				// restart
				valid_q  <= '0;
				global_q <= '0;
				loc_q    <= cfg_data;
				rej_q    <= 1'b0;
			end else begin
				if (state_q == ST_DECODE) begin
					if (op_q == OP_ADVANCE && lo_q == hi_q && !alu_borrow) begin
						global_q <= lo_q;
					end
					if (op_q == OP_TRANSITION && !rej_q) begin
						if (trn_bad) begin
							rej_q <= 1'b1;
						end else begin
							loc_q <= to_q;
							// zero reference and global slot are never cleared by the reset mask
							for (int k = 1; k < CLOCK_SLOTS - 1; k++) begin
								if (mask64[k]) begin
									valid_q[k] <= 1'b0;
								end
							end
						end
					end
				end
				if (state_q == ST_ADV && pend_s1) begin
					valid_q[widx_s1] <= 1'b1;
				end
				if (state_q == ST_CHK_EVAL && !alu_holds) begin
					rej_q <= 1'b1;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_q     <= op_t'(s_axis_tuser);
			lo_q     <= TIME_BITS'(beat.time_low);
			hi_q     <= TIME_BITS'(beat.time_high);
			ca_q     <= beat.clock_a;
			cb_q     <= beat.clock_b;
			bound_q  <= $signed(beat.bound);
			strict_q <= beat.strict;
			unb_q    <= beat.unbounded;
			from_q   <= beat.from_location;
			to_q     <= beat.to_location;
			mask_q   <= beat.reset_mask;
		end
		widx_s1    <= rd_addr;
		rd_vld_s1  <= rd_vld_d;
		rd_glob_s1 <= rd_glob_d;
		if (state_q == ST_DECODE) begin
			unique case (op_q)
				OP_ADVANCE: begin
					if (lo_q != hi_q) begin
						ok_q  <= 1'b0;
						err_q <= ERR_INTERVAL;
					end else if (alu_borrow) begin
						ok_q  <= 1'b0;
						err_q <= ERR_BACKWARD;
					end else begin
						ok_q  <= 1'b1;
						err_q <= ERR_NONE;
						d_q   <= alu_result;
					end
				end
				OP_CHECK: begin
					ok_q  <= !rej_q && unb_q;
					err_q <= ERR_NONE;
				end
				OP_TRANSITION: begin
					ok_q  <= !rej_q && !trn_bad;
					err_q <= ERR_NONE;
				end
				OP_NOP: begin
					ok_q  <= 1'b0;
					err_q <= ERR_NONE;
				end
				default: begin
					ok_q  <= 1'b0;
					err_q <= ERR_NONE;
				end
			endcase
		end
		if (state_q == ST_CHK_B) begin
			av_q <= rd_val;
		end
		if (state_q == ST_CHK_EVAL) begin
			ok_q <= alu_holds;
		end
		if (load_out) begin
			m_data_q <= m_data_d;
		end
	end

	always_comb begin
		m_data_d              = '0;
		m_data_d.ok           = ok_q;
		m_data_d.run_empty    = rej_q;
		m_data_d.error_code   = err_q;
		m_data_d.location_now = loc_q;
		m_data_d.global_time  = TS_W'(global_q);
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

@@ rtl/tacm_chk.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------------------------
// tacm_chk
// Port-level checker for the concrete timed-automaton monitor, bound to the top level.
// ------------------------------------------------------------------------------------------
`include "timed_automaton_concrete_monitor_top_assert.svh"

module tacm_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tvalid,
	input logic                       s_axis_tready,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [tacm_pkg::OUT_W-1:0] m_axis_tdata
);
	import tacm_pkg::*;

	// one operation at a time: the beat just taken keeps the sequencer busy
	`TACM_ASSERT_NEXT(a_busy_after_beat, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")

	`TACM_ASSERT_NOW(a_err_code, m_axis_tvalid, m_axis_tdata[3:2] != 2'd3, "bad error code")

	// a flagged advance never reports success
	`TACM_ASSERT_NOW(a_err_not_ok, m_axis_tvalid && (m_axis_tdata[3:2] != ERR_NONE), !m_axis_tdata[0], "ok with error")

	`TACM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")

endmodule

bind timed_automaton_concrete_monitor_top tacm_chk u_tacm_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
